@@ rtl/krdh_pkg.sv @@
// krdh_pkg: shared constants, codes and stage control types for the
// k-mer repeat distance histogram. No dependencies.
`timescale 1ns / 1ps

package krdh_pkg;

  localparam int unsigned MAX_KMER_DEF      = 4;
  localparam int unsigned BIN_COUNT_DEF     = 100;
  localparam int unsigned POSITION_BITS_DEF = 16;

  localparam int unsigned KLEN_W    = 3;
  localparam int unsigned BIN_IDX_W = 7;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned BINV_W    = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned CNT_W     = 32;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 3'd4;

  // distances below RepeatLimit are binned in steps of ten:
  // d / 10 == (d * RecipMul) >> RecipShift for every d below 1029
  localparam int unsigned RepeatLimit = 1000;
  localparam int unsigned DIST_LO_W   = 10;
  localparam int unsigned RecipMul    = 205;
  localparam int unsigned RECIP_W     = 8;
  localparam int unsigned RecipShift  = 11;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    logic                 vld;
    op_e                  op;
    logic                 hit;
    logic [BIN_IDX_W-1:0] rd_bin;
  } s1_ctl_t;

  typedef struct packed {
    logic vld;
    op_e  op;
    logic hit;
    logic inc;
    logic bin_ok;
  } s2_ctl_t;

endpackage

@@ rtl/krdh_in_if.sv @@
// krdh_in_if: input channel, valid/ready plus one base or bin read request.
// Depends on krdh_pkg.
`timescale 1ns / 1ps

interface krdh_in_if;
  import krdh_pkg::*;

  logic                 valid;
  logic                 ready;
  op_e                  opcode;
  logic [1:0]           base;
  logic                 last_base;
  logic [BIN_IDX_W-1:0] bin_index;

  modport source (output valid, opcode, base, last_base, bin_index, input ready);
  modport sink   (input valid, opcode, base, last_base, bin_index, output ready);
endinterface

@@ rtl/krdh_out_if.sv @@
// krdh_out_if: result channel, valid/ready plus repeat, bin and total fields.
// Depends on krdh_pkg.
`timescale 1ns / 1ps

interface krdh_out_if;
  import krdh_pkg::*;

  logic              valid;
  logic              ready;
  logic              repeat_found;
  logic [DIST_W-1:0] distance;
  logic [BINV_W-1:0] bin_value;
  logic [SUM_W-1:0]  total_distance;
  logic [CNT_W-1:0]  repeat_count;

  modport source (output valid, repeat_found, distance, bin_value, total_distance,
                  repeat_count, input ready);
  modport sink   (input valid, repeat_found, distance, bin_value, total_distance,
                  repeat_count, output ready);
endinterface

@@ rtl/krdh_front.sv @@
// krdh_front: rolling k-mer, fill count, position counter, per-sequence
// valid bits and last-position table lookup. Depends on krdh_pkg.
`timescale 1ns / 1ps

module krdh_front #(
  parameter int unsigned MAX_KMER      = krdh_pkg::MAX_KMER_DEF,
  parameter int unsigned POSITION_BITS = krdh_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                acc_i,
  input  krdh_pkg::op_e                       op_i,
  input  logic [1:0]                          base_i,
  input  logic                                last_i,
  input  logic [krdh_pkg::BIN_IDX_W-1:0]      bin_i,
  input  logic [krdh_pkg::KLEN_W-1:0]         klen_i,
  output krdh_pkg::s1_ctl_t                   ctl_o,
  output logic [POSITION_BITS-1:0]            pos_o,
  output logic [POSITION_BITS-1:0]            lastpos_o
);
  import krdh_pkg::*;

  localparam int unsigned KW     = 2 * MAX_KMER;
  localparam int unsigned TBL    = 1 << KW;
  localparam int unsigned FILL_W = $clog2(MAX_KMER + 1);

  logic [KW-1:0]            kmer_q, kmer_d, key;
  logic [KW-1:0]            mask;
  logic [FILL_W-1:0]        fill_q, fill_d, k;
  logic [POSITION_BITS-1:0] pos_q;
  logic [TBL-1:0]           seen_q;
  logic                     feed, chk;
  s1_ctl_t                  ctl_q;
  logic [POSITION_BITS-1:0] pos_s1_q;
  logic [POSITION_BITS-1:0] rd_q;
  logic [POSITION_BITS-1:0] lastpos_mem [TBL];

  always_comb begin
    if (klen_i == '0) begin
      k = FILL_W'(1);
    end else if (32'(klen_i) > MAX_KMER) begin
      k = FILL_W'(MAX_KMER);
    end else begin
      k = FILL_W'(klen_i);
    end
    for (int i = 0; i < MAX_KMER; i++) begin
      mask[2*i +: 2] = {2{FILL_W'(i) < k}};
    end
    kmer_d = KW'({kmer_q, base_i});
    key    = kmer_d & mask;
    fill_d = (fill_q < FILL_W'(MAX_KMER)) ? fill_q + FILL_W'(1) : fill_q;
    chk    = (fill_d >= k);
    feed   = acc_i && (op_i == OP_FEED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_q <= '0;
      fill_q <= '0;
      pos_q  <= '0;
      seen_q <= '0;
      ctl_q  <= '0;
    end else begin
      if (feed) begin
        if (last_i) begin
          kmer_q <= '0;
          fill_q <= '0;
          pos_q  <= '0;
          seen_q <= '0;
        end else begin
          kmer_q <= kmer_d;
          fill_q <= fill_d;
          if (pos_q != '1) begin
            pos_q <= pos_q + POSITION_BITS'(1);
          end
          if (chk) begin
            seen_q[key] <= 1'b1;
          end
        end
      end
      if (en_i) begin
        ctl_q.vld    <= acc_i;
        ctl_q.op     <= op_i;
        ctl_q.hit    <= feed && chk && seen_q[key];
        ctl_q.rd_bin <= bin_i;
      end
    end
  end

  // the table is read on every advance; its entry is used only when the valid bit gave a hit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q     <= lastpos_mem[key];
      pos_s1_q <= pos_q;
      if (feed && chk) begin
        lastpos_mem[key] <= pos_q;
      end
    end
  end

  assign ctl_o     = ctl_q;
  assign pos_o     = pos_s1_q;
  assign lastpos_o = rd_q;

endmodule

@@ rtl/krdh_hist.sv @@
// krdh_hist: histogram bin memory with reset-cleared valid bits and forwarding
// of a write taken with a read of the same bin, for read-modify-write. Depends on krdh_pkg.
`timescale 1ns / 1ps

module krdh_hist #(
  parameter int unsigned BIN_COUNT = krdh_pkg::BIN_COUNT_DEF,
  localparam int unsigned BW       = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [BW-1:0]                 rd_bin_i,
  input  logic                          wr_i,
  input  logic [BW-1:0]                 wr_bin_i,
  input  logic [krdh_pkg::BINV_W-1:0]   wr_val_i,
  output logic [krdh_pkg::BINV_W-1:0]   rd_val_o
);
  import krdh_pkg::*;

  logic [BINV_W-1:0]    bin_mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] bvld_q;
  logic [BINV_W-1:0]    rd_q;
  logic                 rd_vld_q;
  logic [BW-1:0]        rd_bin_q;
  logic                 fwd_vld_q;
  logic [BW-1:0]        fwd_bin_q;
  logic [BINV_W-1:0]    fwd_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q    <= '0;
      rd_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else if (en_i) begin
      rd_vld_q  <= bvld_q[rd_bin_i];
      fwd_vld_q <= wr_i;
      if (wr_i) begin
        bvld_q[wr_bin_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q      <= bin_mem[rd_bin_i];
      rd_bin_q  <= rd_bin_i;
      fwd_bin_q <= wr_bin_i;
      fwd_val_q <= wr_val_i;
      if (wr_i) begin
        bin_mem[wr_bin_i] <= wr_val_i;
      end
    end
  end

  always_comb begin
    if (fwd_vld_q && (fwd_bin_q == rd_bin_q)) begin
      rd_val_o = fwd_val_q;
    end else if (rd_vld_q) begin
      rd_val_o = rd_q;
    end else begin
      rd_val_o = '0;
    end
  end

endmodule

@@ rtl/kmer_repeat_distance_histogram.sv @@
// kmer_repeat_distance_histogram: top level, length register, distance and
// binning stage, totals and result register. Depends on krdh_pkg, krdh_in_if,
// krdh_out_if, krdh_front and krdh_hist.
//
//   port      dir   handshake       beat
//   cfg       in    cfg_we_i        kmer length, 3 bits
//   item_i    in    valid/ready     opcode, base, last_base, bin_index
//   result_o  out   valid/ready     repeat_found, distance, bin_value, totals
//
// One beat per cycle while the result register is empty or taken; each item
// passes the table read, the distance and bin read, then the histogram update.
// All stages advance together whenever the result register is empty or taken,
// so item_i.ready drops only while a held result is not taken.
// Reset clears sequence state, histogram valid bits and totals at once;
// the length register resets to 4.
`timescale 1ns / 1ps

module kmer_repeat_distance_histogram #(
  parameter int unsigned MAX_KMER      = krdh_pkg::MAX_KMER_DEF,
  parameter int unsigned BIN_COUNT     = krdh_pkg::BIN_COUNT_DEF,
  parameter int unsigned POSITION_BITS = krdh_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [krdh_pkg::KLEN_W-1:0]  cfg_wdata_i,
  krdh_in_if.sink                      item_i,
  krdh_out_if.source                   result_o
);
  import krdh_pkg::*;

  localparam int unsigned BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  logic [KLEN_W-1:0]        klen_q;
  logic                     en, acc;
  s1_ctl_t                  s1;
  logic [POSITION_BITS-1:0] s1_pos, s1_lastpos, s1_d;
  logic [DIST_W-1:0]        s1_dist;
  logic [DIST_LO_W+RECIP_W-1:0] prod;
  logic [BIN_IDX_W-1:0]     quot;
  logic                     s1_inc;
  logic [BW-1:0]            hist_addr;

  s2_ctl_t                  s2_q;
  logic [POSITION_BITS-1:0] s2_d_q;
  logic [DIST_W-1:0]        s2_dist_q;
  logic [BW-1:0]            s2_bin_q;
  logic [BINV_W-1:0]        hist_rd, hist_new;
  logic                     feed_hit;

  logic [SUM_W:0]           sum_ext;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic                     out_vld_q;
  logic                     rep_q;
  logic [DIST_W-1:0]        dist_q;
  logic [BINV_W-1:0]        binv_q;

  assign en           = !out_vld_q || result_o.ready;
  assign acc          = item_i.valid && en;
  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KLEN_RESET;
    end else if (cfg_we_i) begin
      klen_q <= cfg_wdata_i;
    end
  end

  krdh_front #(
    .MAX_KMER      (MAX_KMER),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .acc_i     (acc),
    .op_i      (item_i.opcode),
    .base_i    (item_i.base),
    .last_i    (item_i.last_base),
    .bin_i     (item_i.bin_index),
    .klen_i    (klen_q),
    .ctl_o     (s1),
    .pos_o     (s1_pos),
    .lastpos_o (s1_lastpos)
  );

  // distance, saturated output copy and bin number
  always_comb begin
    s1_d    = s1_pos - s1_lastpos;
    s1_dist = (32'(s1_d) > 32'hFFFF) ? '1 : DIST_W'(s1_d);
    prod    = DIST_LO_W'(s1_d) * RECIP_W'(RecipMul);
    quot    = BIN_IDX_W'(prod >> RecipShift);
    s1_inc  = s1.hit && (32'(s1_d) < RepeatLimit) && (32'(quot) < BIN_COUNT);
    if (s1.op == OP_READ) begin
      hist_addr = BW'(s1.rd_bin);
    end else begin
      hist_addr = BW'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en) begin
      s2_q.vld    <= s1.vld;
      s2_q.op     <= s1.op;
      s2_q.hit    <= s1.hit;
      s2_q.inc    <= s1.vld && s1_inc;
      s2_q.bin_ok <= 32'(s1.rd_bin) < BIN_COUNT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_d_q    <= s1_d;
      s2_dist_q <= s1_dist;
      s2_bin_q  <= hist_addr;
    end
  end

  krdh_hist #(
    .BIN_COUNT (BIN_COUNT)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .rd_bin_i (hist_addr),
    .wr_i     (en && s2_q.inc),
    .wr_bin_i (s2_bin_q),
    .wr_val_i (hist_new),
    .rd_val_o (hist_rd)
  );

  always_comb begin
    hist_new = (hist_rd == '1) ? hist_rd : hist_rd + BINV_W'(1);
    feed_hit = s2_q.vld && (s2_q.op == OP_FEED) && s2_q.hit;
    sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(s2_d_q);
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    if (feed_hit) begin
      sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      if (cnt_q != '1) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      out_vld_q <= s2_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rep_q  <= feed_hit;
      dist_q <= feed_hit ? s2_dist_q : '0;
      binv_q <= (s2_q.op == OP_READ && s2_q.bin_ok) ? hist_rd : '0;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.repeat_found   = rep_q;
  assign result_o.distance       = dist_q;
  assign result_o.bin_value      = binv_q;
  assign result_o.total_distance = sum_q;
  assign result_o.repeat_count   = cnt_q;

  a_no_dist_without_repeat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rep_q) |-> (dist_q == '0))
    else $error("distance reported without a repeat");

  a_totals_monotone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_q >= $past(sum_q)) && (cnt_q >= $past(cnt_q)))
    else $error("running totals decreased");

  a_totals_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(sum_q) && $stable(cnt_q)))
    else $error("totals moved while the pipeline was stalled");

endmodule
